// File: src/mgr_pkg.sv
// package: shared types, constants and the binary32 round-and-pack function
package mgr_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_ONE = 32'h3F80_0000;
    localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;
    localparam int LATENCY = 5;

    typedef enum logic [1:0] {
        FLAG_FULL = 2'd0,
        FLAG_UNIT_DIAG = 2'd1,
        FLAG_UNIT_ANTI = 2'd2,
        FLAG_IDENT = 2'd3
    } t_flag;

    typedef enum logic [2:0] {
        REG_FLAG = 3'd0,
        REG_H11 = 3'd1,
        REG_H21 = 3'd2,
        REG_H12 = 3'd3,
        REG_H22 = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        SP_FIN = 2'd0,
        SP_INF = 2'd1,
        SP_NAN = 2'd2
    } t_spec;

    // round to nearest even and pack; exponent is at least one
    function automatic logic [31:0] f_pack(input logic sgn, input logic signed [10:0] e,
                                           input logic [23:0] m, input logic g,
                                           input logic st);
        logic [24:0] mr;
        logic signed [10:0] ef;
        logic inc;
        inc = g & (st | m[0]);
        mr = {1'b0, m} + {24'd0, inc};
        ef = e;
        if (mr[24]) begin
            mr = mr >> 1;
            ef = e + 11'sd1;
        end
        if (ef >= 11'sd255) begin
            f_pack = {sgn, 8'hFF, 23'd0};
        end else begin
            f_pack = {sgn, mr[23] ? ef[7:0] : 8'd0, mr[22:0]};
        end
    endfunction

endpackage

// File: src/mgr_if.sv
// interfaces: input pair channel and result pair channel
interface mgr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic        last_item;
    modport source (output valid, output x_value, output y_value, output last_item,
                    input ready);
    modport sink (input valid, input x_value, input y_value, input last_item,
                  output ready);
endinterface

interface mgr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_result;
    logic [31:0] y_result;
    logic        last_result;
    modport source (output valid, output x_result, output y_result, output last_result,
                    input ready);
    modport sink (input valid, input x_result, input y_result, input last_result,
                  output ready);
endinterface

// File: src/mgr_fmul.sv
// binary32 multiplier, three register stages
module mgr_fmul import mgr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    logic [47:0] r1_p;
    logic [8:0]  r1_e;
    logic        r1_s;
    t_spec       r1_sp;

    logic [47:0]        r2_p;
    logic signed [10:0] r2_e;
    logic signed [10:0] r2_sh;
    logic               r2_s;
    t_spec              r2_sp;

    logic [31:0] r3_p;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        na, nb, ia, ib, za, zb;
    t_spec       n_sp;

    always_comb begin
        ea = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        ma = {|i_a[30:23], i_a[22:0]};
        mb = {|i_b[30:23], i_b[22:0]};
        na = (&i_a[30:23]) & (|i_a[22:0]);
        nb = (&i_b[30:23]) & (|i_b[22:0]);
        ia = (&i_a[30:23]) & ~(|i_a[22:0]);
        ib = (&i_b[30:23]) & ~(|i_b[22:0]);
        za = ~(|i_a[30:0]);
        zb = ~(|i_b[30:0]);
        if (na | nb | (ia & zb) | (za & ib)) begin
            n_sp = SP_NAN;
        end else if (ia | ib) begin
            n_sp = SP_INF;
        end else begin
            n_sp = SP_FIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p <= ma * mb;
            r1_e <= {1'b0, ea} + {1'b0, eb};
            r1_s <= i_a[31] ^ i_b[31];
            r1_sp <= n_sp;
        end
    end

    // leading one and exponent
    logic [5:0]         lo;
    logic signed [10:0] ev, shv;

    always_comb begin
        lo = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r1_p[i]) lo = 6'(i);
        end
        ev = $signed({2'b00, r1_e}) + $signed({5'd0, lo}) - 11'sd173;
        shv = $signed({5'd0, lo}) - 11'sd23 + ((ev < 11'sd1) ? (11'sd1 - ev) : 11'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p <= r1_p;
            r2_e <= (ev < 11'sd1) ? 11'sd1 : ev;
            r2_sh <= shv;
            r2_s <= r1_s;
            r2_sp <= r1_sp;
        end
    end

    // align, round, pack
    logic [72:0] pext, tsh;
    logic [6:0]  rs;
    logic [4:0]  lsh;
    logic [23:0] m;
    logic        g, st;
    logic [31:0] n_p;

    always_comb begin
        pext = {r2_p, 25'd0};
        rs = (r2_sh > 11'sd73) ? 7'd73 : 7'(r2_sh);
        lsh = 5'(-r2_sh);
        tsh = pext >> rs;
        if (r2_sh < 11'sd0) begin
            m = 24'(r2_p << lsh);
            g = 1'b0;
            st = 1'b0;
        end else begin
            m = tsh[48:25];
            g = tsh[24];
            st = (|tsh[23:0]) | (|(pext & ~({73{1'b1}} << rs)));
        end
        case (r2_sp)
            SP_NAN: n_p = CANON_NAN;
            SP_INF: n_p = {r2_s, 8'hFF, 23'd0};
            default: begin
                if (r2_p == 48'd0) begin
                    n_p = {r2_s, 31'd0};
                end else begin
                    n_p = f_pack(r2_s, r2_e, m, g, st);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p <= n_p;
        end
    end

    assign o_p = r3_p;

endmodule

// File: src/mgr_fadd.sv
// binary32 adder, two register stages
module mgr_fadd import mgr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);

    logic [27:0] r1_sum;
    logic [7:0]  r1_e;
    logic        r1_s;
    logic        r1_zs;
    t_spec       r1_sp;

    logic [31:0] r2_s;

    logic [31:0] big, sml;
    logic [7:0]  eg, es, d;
    logic [4:0]  dd;
    logic [26:0] ax, bx, bsh, bp;
    logic        na, nb, ia, ib;
    t_spec       n_sp;
    logic        n_sgn;

    always_comb begin
        if (i_a[30:0] >= i_b[30:0]) begin
            big = i_a;
            sml = i_b;
        end else begin
            big = i_b;
            sml = i_a;
        end
        eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d = eg - es;
        dd = (d > 8'd27) ? 5'd27 : d[4:0];
        ax = {|big[30:23], big[22:0], 3'b000};
        bx = {|sml[30:23], sml[22:0], 3'b000};
        bsh = bx >> dd;
        bp = {bsh[26:1], bsh[0] | (|(bx & ~({27{1'b1}} << dd)))};
        na = (&i_a[30:23]) & (|i_a[22:0]);
        nb = (&i_b[30:23]) & (|i_b[22:0]);
        ia = (&i_a[30:23]) & ~(|i_a[22:0]);
        ib = (&i_b[30:23]) & ~(|i_b[22:0]);
        n_sgn = big[31];
        if (na | nb | (ia & ib & (i_a[31] ^ i_b[31]))) begin
            n_sp = SP_NAN;
        end else if (ia | ib) begin
            n_sp = SP_INF;
            n_sgn = ia ? i_a[31] : i_b[31];
        end else begin
            n_sp = SP_FIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sum <= (big[31] ^ sml[31]) ? ({1'b0, ax} - {1'b0, bp})
                                          : ({1'b0, ax} + {1'b0, bp});
            r1_e <= eg;
            r1_s <= n_sgn;
            r1_zs <= i_a[31] & i_b[31];
            r1_sp <= n_sp;
        end
    end

    // normalize, round, pack
    logic [4:0]         k, lsh;
    logic [7:0]         emax;
    logic [26:0]        nrm;
    logic signed [10:0] ef;
    logic [31:0]        n_s;

    always_comb begin
        k = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (r1_sum[i]) k = 5'(i);
        end
        lsh = 5'd26 - k;
        emax = r1_e - 8'd1;
        if ({3'd0, lsh} > emax) lsh = emax[4:0];
        if (r1_sum[27]) begin
            nrm = {r1_sum[27:2], r1_sum[1] | r1_sum[0]};
            ef = $signed({3'd0, r1_e}) + 11'sd1;
        end else begin
            nrm = r1_sum[26:0] << lsh;
            ef = $signed({3'd0, r1_e}) - $signed({6'd0, lsh});
        end
        case (r1_sp)
            SP_NAN: n_s = CANON_NAN;
            SP_INF: n_s = {r1_s, 8'hFF, 23'd0};
            default: begin
                if (r1_sum == 28'd0) begin
                    n_s = {r1_zs, 31'd0};
                end else begin
                    n_s = f_pack(r1_s, ef, nrm[26:3], nrm[2], |nrm[1:0]);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_s <= (n_s[30:23] == 8'hFF && n_s[22:0] != 23'd0) ? CANON_NAN : n_s;
        end
    end

    assign o_s = r2_s;

endmodule

// File: src/modified_givens_rotation_apply.sv
// top level: modified givens rotation on one binary32 pair per beat
//  channel  | dir | handshake       | payload
//  i_in     | in  | valid / ready   | x_value, y_value, last_item
//  o_out    | out | valid / ready   | x_result, y_result, last_result
//  i_cfg_*  | in  | write enable    | register index, 32-bit data
// one beat per cycle while the output is not stalled; 3 multiply stages, 2 add stages
// synchronous active-low reset clears valid bits and the configuration registers to reset values
// a stalled output freezes the whole pipe; nothing is dropped or repeated
module modified_givens_rotation_apply import mgr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mgr_in_if.sink      i_in,
    mgr_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_flag       r_flag;
    logic [31:0] r_h11, r_h21, r_h12, r_h22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= FLAG_IDENT;
            r_h11 <= 32'd0;
            r_h21 <= 32'd0;
            r_h12 <= 32'd0;
            r_h22 <= 32'd0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FLAG: r_flag <= t_flag'(i_cfg_data[1:0]);
                REG_H11: r_h11 <= i_cfg_data;
                REG_H21: r_h21 <= i_cfg_data;
                REG_H12: r_h12 <= i_cfg_data;
                REG_H22: r_h22 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_ce;
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] r_last, r_ident;
    logic [31:0] r_xb [LATENCY];
    logic [31:0] r_yb [LATENCY];

    assign w_ce = ~r_vld[LATENCY-1] | o_out.ready;
    assign i_in.ready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LATENCY-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_last <= {r_last[LATENCY-2:0], i_in.last_item};
            r_ident <= {r_ident[LATENCY-2:0], r_flag == FLAG_IDENT};
            r_xb[0] <= i_in.x_value;
            r_yb[0] <= i_in.y_value;
            for (int i = 1; i < LATENCY; i++) begin
                r_xb[i] <= r_xb[i-1];
                r_yb[i] <= r_yb[i-1];
            end
        end
    end

    // coefficient selection
    logic [31:0] ca, cb, cc, cd;

    always_comb begin
        ca = r_h11;
        cb = r_h12;
        cc = r_h21;
        cd = r_h22;
        case (r_flag)
            FLAG_UNIT_DIAG: begin
                ca = FP_ONE;
                cd = FP_ONE;
            end
            FLAG_UNIT_ANTI: begin
                cb = FP_ONE;
                cc = FP_NEG_ONE;
            end
            default: ;
        endcase
    end

    logic [31:0] p_ax, p_by, p_cx, p_dy, s_x, s_y;

    mgr_fmul u_mul_ax (.i_clk(i_clk), .i_en(w_ce), .i_a(ca), .i_b(i_in.x_value), .o_p(p_ax));
    mgr_fmul u_mul_by (.i_clk(i_clk), .i_en(w_ce), .i_a(cb), .i_b(i_in.y_value), .o_p(p_by));
    mgr_fmul u_mul_cx (.i_clk(i_clk), .i_en(w_ce), .i_a(cc), .i_b(i_in.x_value), .o_p(p_cx));
    mgr_fmul u_mul_dy (.i_clk(i_clk), .i_en(w_ce), .i_a(cd), .i_b(i_in.y_value), .o_p(p_dy));

    mgr_fadd u_add_x (.i_clk(i_clk), .i_en(w_ce), .i_a(p_ax), .i_b(p_by), .o_s(s_x));
    mgr_fadd u_add_y (.i_clk(i_clk), .i_en(w_ce), .i_a(p_cx), .i_b(p_dy), .o_s(s_y));

    assign o_out.valid = r_vld[LATENCY-1];
    assign o_out.x_result = r_ident[LATENCY-1] ? r_xb[LATENCY-1] : s_x;
    assign o_out.y_result = r_ident[LATENCY-1] ? r_yb[LATENCY-1] : s_y;
    assign o_out.last_result = r_last[LATENCY-1];

endmodule

// File: src/mgr_chk.sv
// checker: port-level properties of the rotation block, bound to the top level
module mgr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x,
    input logic [31:0] i_out_y,
    input logic        i_out_last
);

    // stalled result beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_last))
        else $error("result payload changed under stall");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an empty output stage never blocks input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with free output stage");

    // a ready output never blocks input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

endmodule

bind modified_givens_rotation_apply mgr_chk u_mgr_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_x(o_out.x_result),
    .i_out_y(o_out.y_result),
    .i_out_last(o_out.last_result)
);
